// File: hdl/arm_gravity_current_feedforward_defines.svh
// Assertion macros for the gravity feedforward block.
// Included by the top level only; no other dependencies.
`ifndef ARM_GRAVITY_CURRENT_FEEDFORWARD_DEFINES_SVH
`define ARM_GRAVITY_CURRENT_FEEDFORWARD_DEFINES_SVH
`ifndef SYNTH
`define AGCF_ASSERT_IMPLY(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
`define AGCF_ASSERT_AFTER(label, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define AGCF_ASSERT_IMPLY(label, a, b)
`define AGCF_ASSERT_AFTER(label, a, b)
`endif
`endif

// File: hdl/agcf_pkg.sv
// Shared types and constants for the gravity feedforward block.
// No dependencies.
package agcf_pkg;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = PI_Q30 / 2;
  localparam longint TWO_PI_Q30  = 2 * PI_Q30;
  localparam longint OFFSET_1    = HALF_PI_Q30 + (65 * PI_Q30) / 180;
  localparam longint OFFSET_2    = -((146 * PI_Q30) / 180);
  localparam longint OFFSET_3    = (102 * PI_Q30) / 180;
  localparam int     TAYLOR_TERMS = 12;

  localparam logic [3:0] REG_MASS_1  = 4'd0;
  localparam logic [3:0] REG_MASS_2  = 4'd1;
  localparam logic [3:0] REG_MASS_3  = 4'd2;
  localparam logic [3:0] REG_GRAVITY = 4'd3;
  localparam logic [3:0] REG_LIMIT   = 4'd4;
  localparam logic [3:0] REG_SCALE_1 = 4'd5;
  localparam logic [3:0] REG_SCALE_2 = 4'd6;
  localparam logic [3:0] REG_SCALE_3 = 4'd7;

  typedef struct packed {
    logic               valid;
    logic [1:0]         tag;
    logic [2:0]         mask;
    logic               is_sin;
    logic               neg;
    logic [31:0]        t;
    logic signed [33:0] acc;
    logic [31:0]        x2;
  } lane_t;

  typedef struct packed {
    logic [15:0] m1;
    logic [15:0] m2;
    logic [15:0] m3;
    logic [15:0] g;
    logic [14:0] limit;
    logic [15:0] s1;
    logic [15:0] s2;
    logic [15:0] s3;
  } cfg_t;
endpackage

// File: hdl/agcf_front.sv
// Front end: accepts joint samples, forms summed angles, reduces and squares them.
// Depends on agcf_pkg.
module agcf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [17:0]  angle_1,
  input  logic signed [17:0]  angle_2,
  input  logic signed [17:0]  angle_3,
  input  logic signed [15:0]  speed_1,
  input  logic signed [15:0]  speed_2,
  input  logic signed [15:0]  speed_3,
  input  logic [14:0]         limit,
  output agcf_pkg::lane_t     lane_out
);
  import agcf_pkg::*;

  logic busy;
  logic [1:0] cnt;
  logic signed [39:0] p1, p2, p3, p1c, p2c, p3c, psel;
  logic [2:0] mask, mask_c;
  logic accept;
  logic [39:0] red;
  logic r_valid, q_valid;
  logic [1:0] r_tag, q_tag;
  logic [2:0] r_mask, q_mask;
  logic [32:0] r_m;
  logic [30:0] q_x;
  logic q_sin, q_neg;
  logic [1:0] qc;
  logic [32:0] qoff;
  logic [61:0] sq;

  function automatic logic cut(input logic signed [15:0] s, input logic [14:0] lim);
    logic [16:0] e, mag;
    e = {s[15], s};
    mag = s[15] ? (17'd0 - e) : e;
    return mag >= {2'b00, lim};
  endfunction

  assign in_ready = !rst && adv && (!busy || cnt == 2'd2);
  assign accept = in_valid && in_ready;

  always_comb begin
    p1c = 40'(OFFSET_1) - {{5{angle_1[17]}}, angle_1, 17'b0};
    p2c = p1c + 40'(OFFSET_2) - {{5{angle_2[17]}}, angle_2, 17'b0};
    p3c = p2c + 40'(OFFSET_3) - {{5{angle_3[17]}}, angle_3, 17'b0};
    mask_c = {cut(speed_3, limit), cut(speed_2, limit), cut(speed_1, limit)};
  end

  always_comb begin
    case (cnt)
      2'd0: psel = p1;
      2'd1: psel = p2;
      default: psel = p3;
    endcase
    red = 40'($unsigned(psel) + 40'(8 * TWO_PI_Q30));
    for (int j = 4; j >= 0; j--) begin
      if (red >= 40'(TWO_PI_Q30 <<< j)) red = red - 40'(TWO_PI_Q30 <<< j);
    end
  end

  always_comb begin
    if (r_m >= 33'(3 * HALF_PI_Q30)) begin
      qc = 2'd3; qoff = 33'(3 * HALF_PI_Q30);
    end else if (r_m >= 33'(2 * HALF_PI_Q30)) begin
      qc = 2'd2; qoff = 33'(2 * HALF_PI_Q30);
    end else if (r_m >= 33'(HALF_PI_Q30)) begin
      qc = 2'd1; qoff = 33'(HALF_PI_Q30);
    end else begin
      qc = 2'd0; qoff = 33'd0;
    end
  end

  assign sq = {31'b0, q_x} * {31'b0, q_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= 2'd0;
      r_valid <= 1'b0;
      q_valid <= 1'b0;
      lane_out.valid <= 1'b0;
    end else if (adv) begin
      if (busy && cnt != 2'd2) begin
        cnt <= cnt + 2'd1;
      end else begin
        busy <= accept;
        cnt <= 2'd0;
      end
      r_valid <= busy;
      q_valid <= r_valid;
      lane_out.valid <= q_valid;
    end
    if (adv) begin
      if (accept) begin
        p1 <= p1c;
        p2 <= p2c;
        p3 <= p3c;
        mask <= mask_c;
      end
      r_m <= red[32:0];
      r_tag <= cnt;
      r_mask <= mask;
      q_x <= 31'(r_m - qoff);
      q_sin <= qc[0];
      q_neg <= (qc == 2'd1) || (qc == 2'd2);
      q_tag <= r_tag;
      q_mask <= r_mask;
      lane_out.tag <= q_tag;
      lane_out.mask <= q_mask;
      lane_out.is_sin <= q_sin;
      lane_out.neg <= q_neg;
      lane_out.x2 <= sq[61:30];
      lane_out.t <= q_sin ? {1'b0, q_x} : 32'h4000_0000;
      lane_out.acc <= q_sin ? {3'b000, q_x} : 34'sh0_4000_0000;
    end
  end
endmodule

// File: hdl/agcf_cell.sv
// One Taylor term cell: multiply by x squared, divide by the term constant, accumulate.
// Depends on agcf_pkg.
module agcf_cell #(
  parameter int K = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  agcf_pkg::lane_t lane_in,
  output agcf_pkg::lane_t lane_out
);
  import agcf_pkg::*;

  localparam int DS = (2 * K) * (2 * K + 1);
  localparam int DC = (2 * K - 1) * (2 * K);
  localparam int LS = $clog2(DS);
  localparam int LC = $clog2(DC);
  localparam logic [33:0] MS = 34'(((66'd1 << (32 + LS)) + 66'(DS) - 66'd1) / 66'(DS));
  localparam logic [33:0] MC = 34'(((66'd1 << (32 + LC)) + 66'(DC) - 66'd1) / 66'(DC));

  lane_t mid;
  logic [63:0] pa;
  logic [65:0] pb;
  logic [31:0] tq;

  assign pa = {32'b0, lane_in.t} * {32'b0, lane_in.x2};
  assign pb = {34'b0, mid.t} * {32'b0, (mid.is_sin ? MS : MC)};
  assign tq = mid.is_sin ? 32'(pb >> (32 + LS)) : 32'(pb >> (32 + LC));

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
      lane_out.valid <= 1'b0;
    end else if (adv) begin
      mid.valid <= lane_in.valid;
      lane_out.valid <= mid.valid;
    end
    if (adv) begin
      mid.tag <= lane_in.tag;
      mid.mask <= lane_in.mask;
      mid.is_sin <= lane_in.is_sin;
      mid.neg <= lane_in.neg;
      mid.x2 <= lane_in.x2;
      mid.acc <= lane_in.acc;
      mid.t <= pa[61:30];
      lane_out.tag <= mid.tag;
      lane_out.mask <= mid.mask;
      lane_out.is_sin <= mid.is_sin;
      lane_out.neg <= mid.neg;
      lane_out.x2 <= mid.x2;
      lane_out.t <= tq;
      lane_out.acc <= (K % 2 == 1) ? mid.acc - $signed({2'b00, tq})
                                   : mid.acc + $signed({2'b00, tq});
    end
  end
endmodule

// File: hdl/agcf_tail.sv
// Back end: rounds the cosines, collects three per sample, forms torques and currents.
// Depends on agcf_pkg.
module agcf_tail #(
  parameter int TF = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  agcf_pkg::lane_t    lane_in,
  input  agcf_pkg::cfg_t     cfg,
  output logic               out_valid,
  output logic signed [15:0] current_1,
  output logic signed [15:0] current_2,
  output logic signed [15:0] current_3,
  output logic [2:0]         zeroed_mask
);
  import agcf_pkg::*;

  localparam int SH = 30 - TF;
  localparam int CW = TF + 2;
  localparam int PW = TF + 35;
  localparam int NW = TF + 37;

  logic signed [33:0] v;
  logic signed [34:0] vr;
  logic signed [CW-1:0] cosv, c0, c1;
  logic [31:0] gm1, gm2, gm3;
  logic f1_valid, f2_valid, f3_valid;
  logic [2:0] f1_mask, f2_mask, f3_mask;
  logic signed [PW-1:0] pr1, pr2, pr3;
  logic signed [NW-1:0] n1, n2, n3;
  logic signed [36:0] tau1, tau2, tau3;
  logic signed [53:0] cu1, cu2, cu3;

  function automatic logic signed [15:0] sat(input logic signed [53:0] x);
    logic signed [53:0] r;
    r = (x + 54'sd268435456) >>> 29;
    if (r > 54'sd32767) return 16'sd32767;
    if (r < -54'sd32768) return -16'sd32768;
    return 16'(r);
  endfunction

  always_comb begin
    v = lane_in.neg ? -lane_in.acc : lane_in.acc;
    vr = 35'(v) + 35'(64'sd1 <<< (SH - 1));
    cosv = CW'(vr >>> SH);
    n3 = NW'(pr3);
    n2 = n3 + NW'(pr2);
    n1 = n2 + NW'(pr1);
  end

  always_ff @(posedge clk) begin
    gm1 <= {16'b0, cfg.m1} * {16'b0, cfg.g};
    gm2 <= {16'b0, cfg.m2} * {16'b0, cfg.g};
    gm3 <= {16'b0, cfg.m3} * {16'b0, cfg.g};
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= lane_in.valid && lane_in.tag == 2'd2;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
      out_valid <= f3_valid;
    end
    if (adv) begin
      if (lane_in.valid && lane_in.tag == 2'd0) c0 <= cosv;
      if (lane_in.valid && lane_in.tag == 2'd1) c1 <= cosv;
      pr1 <= $signed({1'b0, gm1}) * c0;
      pr2 <= $signed({1'b0, gm2}) * c1;
      pr3 <= $signed({1'b0, gm3}) * cosv;
      f1_mask <= lane_in.mask;
      tau1 <= 37'((-n1 + NW'(64'sd1 <<< (TF - 1))) >>> TF);
      tau2 <= 37'((-n2 + NW'(64'sd1 <<< (TF - 1))) >>> TF);
      tau3 <= 37'((-n3 + NW'(64'sd1 <<< (TF - 1))) >>> TF);
      f2_mask <= f1_mask;
      cu1 <= tau1 * $signed({1'b0, cfg.s1});
      cu2 <= tau2 * $signed({1'b0, cfg.s2});
      cu3 <= tau3 * $signed({1'b0, cfg.s3});
      f3_mask <= f2_mask;
      current_1 <= f3_mask[0] ? 16'sd0 : sat(cu1);
      current_2 <= f3_mask[1] ? 16'sd0 : sat(cu2);
      current_3 <= f3_mask[2] ? 16'sd0 : sat(cu3);
      zeroed_mask <= f3_mask;
    end
  end
endmodule

// File: hdl/arm_gravity_current_feedforward.sv
// Top level of the three-link arm gravity feedforward block.
// Depends on agcf_pkg, agcf_front, agcf_cell, agcf_tail and the defines header.
//
// One sample (three angles, three speeds) yields one result (three currents and a
// speed cut mask). The three summed angles share one chain of twelve Taylor cells
// and enter it one after another; a new sample is taken at best as the third angle
// of the last one enters reduction. The result passes the front end's input, reduced,
// quadrant and lane registers, each Taylor cell's mid and output registers and the
// back end's product, torque, current and output registers. A stalled output holds
// the whole pipeline. Configuration writes are ready whenever reset is low and must
// be made while no sample is in flight; an index beyond 7 is dropped.
`include "arm_gravity_current_feedforward_defines.svh"
module arm_gravity_current_feedforward #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // angle_1, angle_2, angle_3 (18b each), speed_1, speed_2, speed_3 (16b each), pad
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // current_1, current_2, current_3 (16b each), zeroed_mask (3b), pad
  output logic [55:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import agcf_pkg::*;

  cfg_t cfg;
  logic adv;
  lane_t chain [0:TAYLOR_TERMS];
  logic signed [15:0] cur1, cur2, cur3;
  logic [2:0] zmask;

  assign cfg_ready = !rst;
  // advance the pipeline unless a result is waiting
  assign adv = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.m1 <= 16'd6757;
      cfg.m2 <= 16'd3921;
      cfg.m3 <= 16'd1365;
      cfg.g <= 16'd20091;
      cfg.limit <= 15'd3277;
      cfg.s1 <= 16'd12540;
      cfg.s2 <= 16'd19563;
      cfg.s3 <= 16'd18099;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MASS_1:  cfg.m1 <= cfg_data;
        REG_MASS_2:  cfg.m2 <= cfg_data;
        REG_MASS_3:  cfg.m3 <= cfg_data;
        REG_GRAVITY: cfg.g <= cfg_data;
        REG_LIMIT:   cfg.limit <= cfg_data[14:0];
        REG_SCALE_1: cfg.s1 <= cfg_data;
        REG_SCALE_2: cfg.s2 <= cfg_data;
        REG_SCALE_3: cfg.s3 <= cfg_data;
        default: ;
      endcase
    end
  end

  agcf_front u_front (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .angle_1(s_axis_tdata[17:0]), .angle_2(s_axis_tdata[35:18]),
    .angle_3(s_axis_tdata[53:36]),
    .speed_1(s_axis_tdata[69:54]), .speed_2(s_axis_tdata[85:70]),
    .speed_3(s_axis_tdata[101:86]),
    .limit(cfg.limit), .lane_out(chain[0])
  );

  // one cell per series term, sine and cosine share the cell
  for (genvar k = 1; k <= TAYLOR_TERMS; k++) begin : g_cell
    agcf_cell #(.K(k)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .lane_in(chain[k-1]), .lane_out(chain[k])
    );
  end

  agcf_tail #(.TF(TRIG_FRAC_BITS)) u_tail (
    .clk(clk), .rst(rst), .adv(adv),
    .lane_in(chain[TAYLOR_TERMS]), .cfg(cfg),
    .out_valid(m_axis_tvalid),
    .current_1(cur1), .current_2(cur2), .current_3(cur3), .zeroed_mask(zmask)
  );

  assign m_axis_tdata = {5'b0, zmask, cur3, cur2, cur1};

  `AGCF_ASSERT_IMPLY(a_cut_zero_1, m_axis_tvalid && zmask[0], cur1 == 16'sd0)
  `AGCF_ASSERT_IMPLY(a_cut_zero_3, m_axis_tvalid && zmask[2], cur3 == 16'sd0)
  `AGCF_ASSERT_AFTER(a_reset_empty, rst, !m_axis_tvalid)
endmodule

// File: dv/tb_arm_gravity_current_feedforward.sv
// Self-checking testbench for the three-link arm gravity feedforward block.
// Depends on agcf_pkg and the top level arm_gravity_current_feedforward.
`timescale 1ns / 100ps
module tb_arm_gravity_current_feedforward;
  import agcf_pkg::*;

  localparam int         TRIG_FRAC   = 14;
  localparam int         IDLE_LIMIT  = 4000;  // cycles with no transaction
  localparam int         DRAIN_WAIT  = 60;    // beyond the pipeline latency
  localparam int         PHASE_ITEMS = 155;
  localparam logic [3:0] REG_SPARE   = 4'd12; // decoded by nothing, must be dropped

  typedef struct {
    logic signed [17:0] a1, a2, a3;
    logic signed [15:0] s1, s2, s3;
  } sample_t;

  typedef struct packed {
    logic [2:0]         mask;
    logic signed [15:0] c3, c2, c1;
  } currents_t;

  typedef struct {
    sample_t   smp;
    bit        typed;
    currents_t res;
  } row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  // angle_1, angle_2, angle_3 (18b each), speed_1, speed_2, speed_3 (16b each), pad
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  // current_1, current_2, current_3 (16b each), zeroed_mask (3b), pad
  logic [55:0]  m_axis_tdata;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [3:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  arm_gravity_current_feedforward dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  cfg_t      arm_cfg;          // register image the predictor works from
  currents_t expected_q[$];    // currents still owed by the block
  int        errors = 0;
  int        burst_left = 0;
  int        idle_cycles = 0;
  bit        in_fire, out_fire, cfg_fire;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // floor((v + half) / 2^sh); arithmetic shift floors for negatives too
  function automatic longint round_half_up(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Cosine of a Q30 angle in Q(TRIG_FRAC): quadrant split plus Taylor series
  function automatic longint cos_q30(input longint phi);
    longint m, q, s, c, v;
    longint unsigned x, x2, t;
    int k;
    m = phi % TWO_PI_Q30;
    if (m < 0) m += TWO_PI_Q30;
    q = m / HALF_PI_Q30;
    if (q > 3) q = 3;
    x  = longint'(m - q * HALF_PI_Q30);
    x2 = (x * x) >> 30;
    s = longint'(x);
    t = x;
    for (k = 1; k <= TAYLOR_TERMS; k++) begin
      t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      s = (k % 2) ? s - longint'(t) : s + longint'(t);
    end
    c = longint'(1) <<< 30;
    t = 64'd1 << 30;
    for (k = 1; k <= TAYLOR_TERMS; k++) begin
      t = ((t * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
      c = (k % 2) ? c - longint'(t) : c + longint'(t);
    end
    case (q)
      0:       v = c;
      1:       v = -s;
      2:       v = -c;
      default: v = s;
    endcase
    return round_half_up(v, 30 - TRIG_FRAC);
  endfunction

  function automatic currents_t gravity_currents(input sample_t x, input cfg_t r);
    longint p1, p2, p3, g, n1, n2, n3, cur, mag, spd;
    longint tau [3];
    longint scale [3];
    longint speed [3];
    currents_t o;
    logic signed [15:0] cv [3];
    int i;
    p1 = OFFSET_1 - longint'(x.a1) * 131072;
    p2 = p1 + OFFSET_2 - longint'(x.a2) * 131072;
    p3 = p2 + OFFSET_3 - longint'(x.a3) * 131072;
    g  = longint'(r.g);
    n3 = longint'(r.m3) * g * cos_q30(p3);
    n2 = n3 + longint'(r.m2) * g * cos_q30(p2);
    n1 = n2 + longint'(r.m1) * g * cos_q30(p1);
    tau[0] = round_half_up(-n1, TRIG_FRAC);
    tau[1] = round_half_up(-n2, TRIG_FRAC);
    tau[2] = round_half_up(-n3, TRIG_FRAC);
    scale[0] = r.s1; scale[1] = r.s2; scale[2] = r.s3;
    speed[0] = x.s1; speed[1] = x.s2; speed[2] = x.s3;
    o.mask = '0;
    for (i = 0; i < 3; i++) begin
      spd = speed[i];
      mag = spd < 0 ? -spd : spd;
      if (mag >= longint'(r.limit)) begin
        cur = 0;
        o.mask[i] = 1'b1;
      end else begin
        cur = round_half_up(tau[i] * scale[i], 29);
        if (cur > 32767) cur = 32767;
        if (cur < -32768) cur = -32768;
      end
      cv[i] = cur[15:0];
    end
    o.c1 = cv[0]; o.c2 = cv[1]; o.c3 = cv[2];
    return o;
  endfunction

  // Handshakes are sampled at the falling edge; nothing changes until the next rise
  always @(negedge clk) begin
    in_fire  = s_axis_tvalid && s_axis_tready;
    out_fire = m_axis_tvalid && m_axis_tready;
    cfg_fire = cfg_valid && cfg_ready;
    if (!rst && out_fire) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", m_axis_tdata));
      end else begin
        currents_t e, got;
        e = expected_q.pop_front();
        got = m_axis_tdata[50:0];
        if (got.c1 !== e.c1)
          report_mismatch($sformatf("current_1 %0d, want %0d", got.c1, e.c1));
        if (got.c2 !== e.c2)
          report_mismatch($sformatf("current_2 %0d, want %0d", got.c2, e.c2));
        if (got.c3 !== e.c3)
          report_mismatch($sformatf("current_3 %0d, want %0d", got.c3, e.c3));
        if (got.mask !== e.mask)
          report_mismatch($sformatf("zeroed_mask %b, want %b", got.mask, e.mask));
      end
    end
    // Watchdog: give up if the block goes silent
    if (rst || in_fire || out_fire || cfg_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: switch between full throughput and random stalls, each held for a random stretch
  int stall_mode = 0, stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 300);
    end
    stall_left--;
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Write the whole register set back to back, then drop the spare index
  task automatic load_registers(input cfg_t r);
    logic [15:0] vals [8];
    logic [3:0]  idx [8];
    int i;
    idx  = '{REG_MASS_1, REG_MASS_2, REG_MASS_3, REG_GRAVITY,
             REG_LIMIT, REG_SCALE_1, REG_SCALE_2, REG_SCALE_3};
    vals = '{r.m1, r.m2, r.m3, r.g, {1'b0, r.limit}, r.s1, r.s2, r.s3};
    // the limit register keeps only 15 bits: set the spare top bit now and then
    if ($urandom_range(0, 1)) vals[4][15] = 1'b1;
    for (i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_fire);
    end
    cfg_index <= REG_SPARE;
    cfg_data  <= 16'($urandom);
    do @(posedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
    arm_cfg = r;
  endtask

  // Hold the sample until accepted; bursts of random length with gaps between
  task automatic send_sample(input sample_t x, input bit typed, input currents_t want);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, x.s3, x.s2, x.s1, x.a3, x.a2, x.a1};
    do @(posedge clk); while (!in_fire);
    expected_q.insert(expected_q.size(), typed ? want : gravity_currents(x, arm_cfg));
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_speed(input logic [14:0] lim);
    int l;
    l = lim;
    case ($urandom_range(0, 5))
      0, 1, 2: return (l > 1)
                 ? 16'($urandom_range(0, l - 1) * ($urandom_range(0, 1) ? 1 : -1))
                 : 16'sd0;
      3:       return $urandom_range(0, 1) ? 16'(l) : -16'(l);
      4:       return (l > 0) ? -16'(l - 1) : 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [17:0] pick_angle();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 1) ? 18'sd131071 : -18'sd131072;
      1:       return 18'($urandom_range(0, 12868) * ($urandom_range(0, 1) ? 1 : -1));
      default: return 18'($urandom);
    endcase
  endfunction

  function automatic row_t mk(input int a1, a2, a3, s1, s2, s3);
    row_t r;
    r.smp.a1 = 18'(a1);
    r.smp.a2 = 18'(a2);
    r.smp.a3 = 18'(a3);
    r.smp.s1 = 16'(s1);
    r.smp.s2 = 16'(s2);
    r.smp.s3 = 16'(s3);
    r.typed = 0;
    r.res = '0;
    return r;
  endfunction

  initial begin
    row_t      directed [$];
    row_t      r;
    cfg_t      set;
    currents_t all_cut;
    sample_t   x;
    int ph, n;

    arm_cfg = '{m1: 6757, m2: 3921, m3: 1365, g: 20091, limit: 3277,
                s1: 12540, s2: 19563, s3: 18099};
    all_cut = '{mask: 3'b111, c3: 0, c2: 0, c1: 0};

    // Directed table under the reset register values (limit 3277)
    directed = {directed, mk(0, 0, 0, 0, 0, 0)};
    directed = {directed, mk(131071, 131071, 131071, 0, 0, 0)};
    directed = {directed, mk(-131072, -131072, -131072, 0, 0, 0)};
    directed = {directed, mk(131071, -131072, 0, 1, -1, 100)};
    directed = {directed, mk(-131072, 131071, -1, 3276, -3276, 0)};
    directed = {directed, mk(12868, 0, 0, 0, 3277, 0)};
    directed = {directed, mk(-12868, 6434, -6434, -3277, 0, 3276)};
    directed = {directed, mk(25736, -25736, 12868, 0, 0, -3277)};
    directed = {directed, mk(4, -4, 8191, 16383, -16384, 2000)};
    directed = {directed, mk(65535, -65536, 43690, -2000, 1234, -1)};
    r = mk(1000, -2000, 3000, -32768, -32768, -32768);
    r.typed = 1; r.res = all_cut; directed = {directed, r};
    r = mk(0, 0, 0, 32767, -32768, 3277);
    r.typed = 1; r.res = all_cut; directed = {directed, r};
    r = mk(-131072, 131071, 65537, -3277, 3277, -32767);
    r.typed = 1; r.res = all_cut; directed = {directed, r};
    directed = {directed, mk(21845, -21846, 1, -3276, 3276, 3276)};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_sample(directed[i].smp, directed[i].typed, directed[i].res);

    for (ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: set = '{m1: '1, m2: '1, m3: '1, g: '1, limit: '1, s1: '1, s2: '1, s3: '1};
        1: set = '{default: '0};
        4: set = '{m1: 6757, m2: 3921, m3: 1365, g: 20091, limit: 3277,
                   s1: 12540, s2: 19563, s3: 18099};
        5: set = '{m1: '1, m2: 0, m3: '1, g: 20091, limit: 1, s1: '1, s2: 1, s3: 0};
        default: set = '{m1: 16'($urandom), m2: 16'($urandom), m3: 16'($urandom),
                         g: 16'($urandom), limit: 15'($urandom_range(100, 32767)),
                         s1: 16'($urandom), s2: 16'($urandom), s3: 16'($urandom)};
      endcase
      load_registers(set);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        x.a1 = pick_angle(); x.a2 = pick_angle(); x.a3 = pick_angle();
        x.s1 = pick_speed(arm_cfg.limit);
        x.s2 = pick_speed(arm_cfg.limit);
        x.s3 = pick_speed(arm_cfg.limit);
        // a zero limit cuts every joint whatever the speed
        if (arm_cfg.limit == 0 && n == 0) send_sample(x, 1, all_cut);
        else send_sample(x, 0, all_cut);
      end
    end

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/agcf_pkg.sv
hdl/agcf_front.sv
hdl/agcf_cell.sv
hdl/agcf_tail.sv
hdl/arm_gravity_current_feedforward.sv
dv/tb_arm_gravity_current_feedforward.sv
